// ----- rtl/core/trpe_pkg.sv -----
`default_nettype none
package trpe_pkg;

  localparam int MAX_SYMBOLS      = 16;
  localparam int REPEAT_GAP_TICKS = 100;

  localparam int IDX_W      = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
  localparam int LEN_W      = $clog2(MAX_SYMBOLS + 1);
  localparam int TICK_W     = 16;
  localparam int REP_W      = 8;
  localparam int CHAR_W     = 8;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [LEN_W-1:0]  MAX_LEN  = LEN_W'(MAX_SYMBOLS);
  localparam logic [TICK_W-1:0] GAP_LEN  = TICK_W'(REPEAT_GAP_TICKS);

  // opcodes of an input beat
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // ascii code characters
  localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_ONE  = 8'h31;
  localparam logic [CHAR_W-1:0] CHAR_F    = 8'h46;
  localparam logic [CHAR_W-1:0] CHAR_X    = 8'h58;
  localparam logic [CHAR_W-1:0] CHAR_Z    = 8'h5A;

  typedef enum logic [1:0] {
    SYM_SHORT_SHORT = 2'd0,
    SYM_LONG_LONG   = 2'd1,
    SYM_LONG_SHORT  = 2'd2,
    SYM_SHORT_LONG  = 2'd3
  } sym_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_BUSY    = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_SYNC_HIGH  = 3'd0,
    REG_SYNC_LOW   = 3'd1,
    REG_SHORT_HIGH = 3'd2,
    REG_LONG_HIGH  = 3'd3,
    REG_SHORT_LOW  = 3'd4,
    REG_LONG_LOW   = 3'd5,
    REG_REPEAT     = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [TICK_W-1:0] sync_high_ticks;
    logic [TICK_W-1:0] sync_low_ticks;
    logic [TICK_W-1:0] short_high_ticks;
    logic [TICK_W-1:0] long_high_ticks;
    logic [TICK_W-1:0] short_low_ticks;
    logic [TICK_W-1:0] long_low_ticks;
    logic [REP_W-1:0]  repeat_count;
  } cfg_t;

  typedef struct packed {
    logic              opcode;
    logic [CHAR_W-1:0] symbol_char;
    logic              end_of_code;
  } item_t;

  typedef struct packed {
    logic    pin_level;
    logic    busy_res;
    logic    frame_done;
    status_t push_status;
  } res_t;

endpackage
`default_nettype wire

// ----- rtl/core/trpe_if.sv -----
`default_nettype none
interface trpe_item_if;
  logic                         valid;
  logic                         ready;
  logic                         opcode;
  logic [trpe_pkg::CHAR_W-1:0]  symbol_char;
  logic                         end_of_code;
  modport source (output valid, opcode, symbol_char, end_of_code, input ready);
  modport sink (input valid, opcode, symbol_char, end_of_code, output ready);
endinterface

interface trpe_result_if;
  logic       valid;
  logic       ready;
  logic       pin_level;
  logic       busy_res;
  logic       frame_done;
  logic [1:0] push_status;
  modport source (output valid, pin_level, busy_res, frame_done, push_status, input ready);
  modport sink (input valid, pin_level, busy_res, frame_done, push_status, output ready);
endinterface

interface trpe_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [trpe_pkg::CFG_ADDR_W-1:0]  addr;
  logic [trpe_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/tristate_remote_pulse_encoder_core.sv -----
// Tri-state remote pulse encoder.
// item channel: each beat is either a push of one code character (opcode 0) or
// one microsecond tick (opcode 1). Pushes store '0', '1', 'X'/'F', 'Z' as 2-bit
// symbols; a push with end_of_code set starts sending the stored code
// repeat_count times. Each tick beat returns the pin level for that tick.
// result channel: exactly one beat per item beat, in order, carrying pin_level,
// busy_res, frame_done and push_status (ok, invalid, busy, buffer full).
// cfg channel: writes timing registers 0..6 by index; always ready, and is to be
// written only while no item is in flight.
// Path: an item beat is held in the input register, and its result beat is
// offered from the result register once the staged item has been processed.
// Throughput: one item per cycle while the result receiver takes each beat; the
// per-tick work is a tick counter decrement and segment select.
// When the result receiver stalls, the result register holds and the input
// register fills; item ready drops only once both are full.
// Reset clears all control state and loads the default timing; the pin is low
// and no transmission is running. No clearing pass is needed.
`default_nettype none
module tristate_remote_pulse_encoder_core (
  input wire logic     clk,
  input wire logic     rst,
  trpe_item_if.sink    item,
  trpe_result_if.source result,
  trpe_cfg_if.sink     cfg
);
  import trpe_pkg::*;

  cfg_t  cfg_q;
  item_t item_q;
  logic  item_q_valid;
  logic  adv;
  res_t  res;
  res_t  res_q;
  logic  res_valid;

  assign cfg.ready = 1'b1;

  trpe_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cfg.valid),
    .wr_addr (cfg.addr),
    .wr_data (cfg.data),
    .cfg     (cfg_q)
  );

  // the staged item is processed when the result register can take its beat
  assign adv        = item_q_valid && (!res_valid || result.ready);
  assign item.ready = !item_q_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_q_valid <= 1'b0;
    end else if (item.ready) begin
      item_q_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.ready && item.valid) begin
      item_q <= '{opcode: item.opcode, symbol_char: item.symbol_char,
                  end_of_code: item.end_of_code};
    end
  end

  trpe_engine u_engine (
    .clk  (clk),
    .rst  (rst),
    .go   (adv),
    .item (item_q),
    .cfg  (cfg_q),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_q <= res;
    end
  end

  assign result.valid       = res_valid;
  assign result.pin_level   = res_q.pin_level;
  assign result.busy_res    = res_q.busy_res;
  assign result.frame_done  = res_q.frame_done;
  assign result.push_status = res_q.push_status;

endmodule
`default_nettype wire

// ----- rtl/core/trpe_cfg_regs.sv -----
`default_nettype none
module trpe_cfg_regs (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            wr_en,
  input  wire logic [trpe_pkg::CFG_ADDR_W-1:0] wr_addr,
  input  wire logic [trpe_pkg::CFG_DATA_W-1:0] wr_data,
  output      trpe_pkg::cfg_t                  cfg
);
  import trpe_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_high_ticks  <= TICK_W'(350);
      cfg.sync_low_ticks   <= TICK_W'(10850);
      cfg.short_high_ticks <= TICK_W'(350);
      cfg.long_high_ticks  <= TICK_W'(1050);
      cfg.short_low_ticks  <= TICK_W'(350);
      cfg.long_low_ticks   <= TICK_W'(1050);
      cfg.repeat_count     <= REP_W'(4);
    end else if (wr_en) begin
      unique case (wr_addr)
        REG_SYNC_HIGH:  cfg.sync_high_ticks  <= wr_data[TICK_W-1:0];
        REG_SYNC_LOW:   cfg.sync_low_ticks   <= wr_data[TICK_W-1:0];
        REG_SHORT_HIGH: cfg.short_high_ticks <= wr_data[TICK_W-1:0];
        REG_LONG_HIGH:  cfg.long_high_ticks  <= wr_data[TICK_W-1:0];
        REG_SHORT_LOW:  cfg.short_low_ticks  <= wr_data[TICK_W-1:0];
        REG_LONG_LOW:   cfg.long_low_ticks   <= wr_data[TICK_W-1:0];
        REG_REPEAT:     cfg.repeat_count     <= wr_data[REP_W-1:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/trpe_engine.sv -----
`default_nettype none
module trpe_engine (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            go,
  input  wire trpe_pkg::item_t item,
  input  wire trpe_pkg::cfg_t  cfg,
  output      trpe_pkg::res_t  res
);
  import trpe_pkg::*;

  typedef enum logic [3:0] {
    PH_SYNC_HIGH  = 4'd0,
    PH_SYNC_LOW   = 4'd1,
    PH_SYM_HIGH1  = 4'd2,
    PH_SYM_LOW1   = 4'd3,
    PH_SYM_HIGH2  = 4'd4,
    PH_SYM_LOW2   = 4'd5,
    PH_TRAIL_HIGH = 4'd6,
    PH_TRAIL_LOW  = 4'd7,
    PH_GAP        = 4'd8
  } phase_t;

  logic [1:0]        code_store [MAX_SYMBOLS];
  logic [LEN_W-1:0]  code_length, code_length_next;
  logic              sending, sending_next;
  logic [REP_W-1:0]  repeats_left, repeats_left_next;
  logic [LEN_W-1:0]  symbol_position, symbol_position_next;
  phase_t            phase, phase_next;
  logic [TICK_W-1:0] ticks_left, ticks_left_next;

  logic              store_we;
  logic [1:0]        store_wdata;
  logic [LEN_W-1:0]  rd_pos;
  logic [1:0]        cur_sym;
  logic [TICK_W-1:0] tick_dec;
  logic              code_ok;
  logic [1:0]        code;
  logic [REP_W-1:0]  rep_dec;

  function automatic logic [TICK_W-1:0] seg_len(phase_t ph, logic [1:0] s, cfg_t c);
    logic [TICK_W-1:0] t;
    case (ph)
      PH_SYNC_HIGH:  t = c.sync_high_ticks;
      PH_SYNC_LOW:   t = c.sync_low_ticks;
      PH_SYM_HIGH1:  t = (s == SYM_LONG_LONG || s == SYM_LONG_SHORT) ?
                         c.long_high_ticks : c.short_high_ticks;
      PH_SYM_LOW1:   t = c.short_low_ticks;
      PH_SYM_HIGH2:  t = (s == SYM_LONG_LONG || s == SYM_SHORT_LONG) ?
                         c.long_high_ticks : c.short_high_ticks;
      PH_SYM_LOW2:   t = c.long_low_ticks;
      PH_TRAIL_HIGH: t = c.short_high_ticks;
      PH_TRAIL_LOW:  t = c.long_low_ticks;
      default:       t = GAP_LEN;
    endcase
    // a zero length segment still lasts one tick
    return (t == '0) ? TICK_W'(1) : t;
  endfunction

  // symbol needed by the segment being entered
  always_comb begin
    case (phase)
      PH_SYNC_LOW: rd_pos = '0;
      PH_SYM_LOW2: rd_pos = symbol_position + LEN_W'(1);
      default:     rd_pos = symbol_position;
    endcase
    cur_sym = (rd_pos < MAX_LEN) ? code_store[rd_pos[IDX_W-1:0]] : 2'd0;
  end

  always_comb begin
    code_ok = 1'b1;
    code    = SYM_SHORT_SHORT;
    case (item.symbol_char)
      CHAR_ZERO:      code = SYM_SHORT_SHORT;
      CHAR_ONE:       code = SYM_LONG_LONG;
      CHAR_X, CHAR_F: code = SYM_LONG_SHORT;
      CHAR_Z:         code = SYM_SHORT_LONG;
      default:        code_ok = 1'b0;
    endcase
  end

  assign tick_dec = (ticks_left != '0) ? ticks_left - TICK_W'(1) : '0;
  assign rep_dec  = repeats_left - REP_W'(1);

  always_comb begin
    code_length_next     = code_length;
    sending_next         = sending;
    repeats_left_next    = repeats_left;
    symbol_position_next = symbol_position;
    phase_next           = phase;
    ticks_left_next      = ticks_left;
    store_we             = 1'b0;
    store_wdata          = code;
    res                  = '{pin_level: 1'b0, busy_res: 1'b0, frame_done: 1'b0,
                             push_status: ST_OK};

    if (go) begin
      if (item.opcode == OP_PUSH) begin
        if (sending) begin
          res.push_status = ST_BUSY;
        end else begin
          if (!code_ok) begin
            res.push_status = ST_INVALID;
          end else if (code_length >= MAX_LEN) begin
            res.push_status = ST_FULL;
          end else begin
            store_we         = 1'b1;
            code_length_next = code_length + LEN_W'(1);
          end
          if (item.end_of_code) begin
            if (cfg.repeat_count != '0) begin
              sending_next         = 1'b1;
              repeats_left_next    = cfg.repeat_count;
              symbol_position_next = '0;
              phase_next           = PH_SYNC_HIGH;
              ticks_left_next      = seg_len(PH_SYNC_HIGH, 2'd0, cfg);
            end else begin
              code_length_next = '0;
            end
          end
        end
        res.busy_res = sending_next;
      end else if (sending) begin
        res.busy_res  = 1'b1;
        res.pin_level = (phase == PH_SYNC_HIGH || phase == PH_SYM_HIGH1 ||
                         phase == PH_SYM_HIGH2 || phase == PH_TRAIL_HIGH);
        ticks_left_next = tick_dec;
        if (tick_dec == '0) begin
          case (phase)
            PH_SYNC_HIGH: phase_next = PH_SYNC_LOW;
            PH_SYNC_LOW: begin
              symbol_position_next = '0;
              phase_next = (code_length != '0) ? PH_SYM_HIGH1 : PH_TRAIL_HIGH;
            end
            PH_SYM_HIGH1:  phase_next = PH_SYM_LOW1;
            PH_SYM_LOW1:   phase_next = PH_SYM_HIGH2;
            PH_SYM_HIGH2:  phase_next = PH_SYM_LOW2;
            PH_SYM_LOW2: begin
              symbol_position_next = rd_pos;
              phase_next = (rd_pos < code_length) ? PH_SYM_HIGH1 : PH_TRAIL_HIGH;
            end
            PH_TRAIL_HIGH: phase_next = PH_TRAIL_LOW;
            PH_TRAIL_LOW: begin
              repeats_left_next = rep_dec;
              phase_next        = PH_GAP;
            end
            default: begin
              symbol_position_next = '0;
              phase_next           = PH_SYNC_HIGH;
            end
          endcase
          ticks_left_next = seg_len(phase_next, cur_sym, cfg);
          // last repetition finished
          if (phase == PH_TRAIL_LOW && rep_dec == '0) begin
            sending_next         = 1'b0;
            code_length_next     = '0;
            symbol_position_next = '0;
            phase_next           = PH_SYNC_HIGH;
            ticks_left_next      = '0;
            res.frame_done       = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      code_length     <= '0;
      sending         <= 1'b0;
      repeats_left    <= '0;
      symbol_position <= '0;
      phase           <= PH_SYNC_HIGH;
      ticks_left      <= '0;
    end else begin
      code_length     <= code_length_next;
      sending         <= sending_next;
      repeats_left    <= repeats_left_next;
      symbol_position <= symbol_position_next;
      phase           <= phase_next;
      ticks_left      <= ticks_left_next;
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      code_store[code_length[IDX_W-1:0]] <= store_wdata;
    end
  end

endmodule
`default_nettype wire
